// ----- design/tks_pkg.sv -----
// Shared types, constants and the exponential weight table of the top-k sampler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package tks_pkg;

  localparam int SCORE_W  = 16;
  localparam int TOKEN_W  = 13;
  localparam int WEIGHT_W = 16;
  localparam int INVT_W   = 16;
  localparam int KLIM_W   = 7;
  localparam int RAND_W   = 32;

  // Exponential table over arguments 0 down to -8.
  localparam int EXP_DEPTH = 256;
  localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
  // The magnitude of the argument is Q16.16, so -8 is 8 << 16 = 2^19.
  localparam logic [31:0] EXP_ARG_LIMIT = 32'h0008_0000;
  localparam int EXP_SHIFT = 19 - EXP_IDX_W;

  // Terms of the Taylor sum of exp(-8/EXP_DEPTH) in Q32, each one truncated.
  localparam logic [63:0] EXP_T0  = 64'h1_0000_0000;
  localparam logic [63:0] EXP_T1  = (EXP_T0  * 64'd8) / (64'(EXP_DEPTH) * 64'd1);
  localparam logic [63:0] EXP_T2  = (EXP_T1  * 64'd8) / (64'(EXP_DEPTH) * 64'd2);
  localparam logic [63:0] EXP_T3  = (EXP_T2  * 64'd8) / (64'(EXP_DEPTH) * 64'd3);
  localparam logic [63:0] EXP_T4  = (EXP_T3  * 64'd8) / (64'(EXP_DEPTH) * 64'd4);
  localparam logic [63:0] EXP_T5  = (EXP_T4  * 64'd8) / (64'(EXP_DEPTH) * 64'd5);
  localparam logic [63:0] EXP_T6  = (EXP_T5  * 64'd8) / (64'(EXP_DEPTH) * 64'd6);
  localparam logic [63:0] EXP_T7  = (EXP_T6  * 64'd8) / (64'(EXP_DEPTH) * 64'd7);
  localparam logic [63:0] EXP_T8  = (EXP_T7  * 64'd8) / (64'(EXP_DEPTH) * 64'd8);
  localparam logic [63:0] EXP_T9  = (EXP_T8  * 64'd8) / (64'(EXP_DEPTH) * 64'd9);
  localparam logic [63:0] EXP_T10 = (EXP_T9  * 64'd8) / (64'(EXP_DEPTH) * 64'd10);
  localparam logic [63:0] EXP_T11 = (EXP_T10 * 64'd8) / (64'(EXP_DEPTH) * 64'd11);
  localparam logic [63:0] EXP_T12 = (EXP_T11 * 64'd8) / (64'(EXP_DEPTH) * 64'd12);
  localparam logic [63:0] EXP_T13 = (EXP_T12 * 64'd8) / (64'(EXP_DEPTH) * 64'd13);
  localparam logic [63:0] EXP_T14 = (EXP_T13 * 64'd8) / (64'(EXP_DEPTH) * 64'd14);
  localparam logic [63:0] EXP_T15 = (EXP_T14 * 64'd8) / (64'(EXP_DEPTH) * 64'd15);
  localparam logic [63:0] EXP_T16 = (EXP_T15 * 64'd8) / (64'(EXP_DEPTH) * 64'd16);
  localparam logic [63:0] EXP_T17 = (EXP_T16 * 64'd8) / (64'(EXP_DEPTH) * 64'd17);
  localparam logic [63:0] EXP_T18 = (EXP_T17 * 64'd8) / (64'(EXP_DEPTH) * 64'd18);
  localparam logic [63:0] EXP_T19 = (EXP_T18 * 64'd8) / (64'(EXP_DEPTH) * 64'd19);
  localparam logic [63:0] EXP_T20 = (EXP_T19 * 64'd8) / (64'(EXP_DEPTH) * 64'd20);
  // The step factor of the table: the terms with alternating signs.
  localparam logic [63:0] EXP_STEP = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4 - EXP_T5
                                     + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
                                     - EXP_T11 + EXP_T12 - EXP_T13 + EXP_T14 - EXP_T15
                                     + EXP_T16 - EXP_T17 + EXP_T18 - EXP_T19 + EXP_T20;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KEPT_LIMIT = 2'd0;
  localparam logic [1:0] REG_GREEDY     = 2'd1;
  localparam logic [1:0] REG_INV_TEMP   = 2'd2;

  // Reset values of the registers.
  localparam logic [KLIM_W-1:0] KEPT_LIMIT_RST = 7'd1;
  localparam logic [INVT_W-1:0] INV_TEMP_RST   = 16'd256;

  // Latency of the weight pipeline, from an entry at the head of the chain
  // to its weight.
  localparam int WEIGHT_LAT = 3;

  typedef logic [WEIGHT_W-1:0] exp_table_t [EXP_DEPTH];

  // Commands that the sequencer hands to every cell of the chain.
  typedef struct packed {
    logic insert;  // rank the incoming score
    logic trim;    // drop entries past the current limit
    logic rotate;  // every cell takes its lower neighbor, the head wraps to the tail
    logic clear;   // end of run: empty the chain
  } tks_cell_ctrl_t;

  // exp(-8j/EXP_DEPTH) in Q0.16. The step factor is a 21-term Taylor sum in
  // Q32, and the running product is rounded to nearest at each step.
  function automatic exp_table_t build_exp_table();
    logic [63:0] cur;
    logic [63:0] e;
    exp_table_t  t;
    cur = 64'h1_0000_0000;
    for (int n = 0; n < EXP_DEPTH; n++) begin
      e = (cur + 64'h8000) >> 16;
      t[n] = (e > 64'd65535) ? 16'hFFFF : e[WEIGHT_W-1:0];
      cur = (cur * EXP_STEP + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

// ----- design/tks_stream_if.sv -----
// Valid/ready stream interfaces for the logit input and the token output.
// Depends on tks_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface tks_logit_if;
  import tks_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SCORE_W-1:0]  logit_score;
  logic                       run_last;
  logic        [RAND_W-1:0]   random_word;

  modport source (output valid, output logit_score, output run_last, output random_word,
                  input ready);
  modport sink (input valid, input logit_score, input run_last, input random_word,
                output ready);
endinterface

interface tks_token_if;
  import tks_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] token_id;

  modport source (output valid, output token_id, input ready);
  modport sink (input valid, input token_id, output ready);
endinterface
`default_nettype wire

// ----- design/tks_cell.sv -----
// One cell of the ranking chain: holds one kept score and its id.
// Depends on tks_pkg for the score width and the command struct.
`timescale 1ns / 1ps
`default_nettype none
module tks_cell #(
  parameter int ID_W = 13
) (
  input  wire                              clk,
  input  wire                              rst,
  input  tks_pkg::tks_cell_ctrl_t          ctrl,
  input  wire                              in_range,
  input  wire signed [tks_pkg::SCORE_W-1:0] new_score,
  input  wire        [ID_W-1:0]            new_id,
  input  wire                              prev_ins,
  input  wire signed [tks_pkg::SCORE_W-1:0] prev_score,
  input  wire        [ID_W-1:0]            prev_id,
  input  wire                              prev_valid,
  input  wire signed [tks_pkg::SCORE_W-1:0] next_score,
  input  wire        [ID_W-1:0]            next_id,
  input  wire                              next_valid,
  output logic                             ins,
  output logic signed [tks_pkg::SCORE_W-1:0] score,
  output logic       [ID_W-1:0]            id,
  output logic                             valid
);
  import tks_pkg::*;

  logic take_new;
  logic take_prev;

  // The new score goes ahead of this entry only when strictly greater, so an
  // earlier id wins a tie. The first inserting cell takes the new score, the
  // cells behind it take their upper neighbor.
  assign ins       = in_range && (!valid || (new_score > score));
  assign take_new  = ins && !prev_ins;
  assign take_prev = ins && prev_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.rotate) begin
      valid <= next_valid;
    end else if (ctrl.insert && take_new) begin
      valid <= 1'b1;
    end else if (ctrl.insert && take_prev) begin
      valid <= prev_valid;
    end else if (ctrl.trim && !in_range) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      score <= next_score;
      id    <= next_id;
    end else if (ctrl.insert && take_new) begin
      score <= new_score;
      id    <= new_id;
    end else if (ctrl.insert && take_prev) begin
      score <= prev_score;
      id    <= prev_id;
    end
  end

endmodule
`default_nettype wire

// ----- design/tks_weight.sv -----
// Three-stage weight pipeline: score gap, scaling by the inverse temperature,
// exponential table lookup. Depends on tks_pkg for the table and widths.
`timescale 1ns / 1ps
`default_nettype none
module tks_weight #(
  parameter int ID_W = 13
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               issue,
  input  wire signed [tks_pkg::SCORE_W-1:0] top_score,
  input  wire signed [tks_pkg::SCORE_W-1:0] score,
  input  wire        [ID_W-1:0]             id,
  input  wire        [tks_pkg::INVT_W-1:0]  inv_temp,
  output logic                              w_valid,
  output logic       [tks_pkg::WEIGHT_W-1:0] w,
  output logic       [ID_W-1:0]             w_id
);
  import tks_pkg::*;

  logic signed [SCORE_W:0]   diff;
  logic        [SCORE_W-1:0] gap1;
  logic                      v1;
  logic        [ID_W-1:0]    id1;
  logic        [31:0]        mag2;
  logic                      v2;
  logic        [ID_W-1:0]    id2;
  logic        [31:0]        scaled;
  logic        [EXP_IDX_W-1:0] idx;

  assign diff   = {top_score[SCORE_W-1], top_score} - {score[SCORE_W-1], score};
  assign scaled = mag2 >> EXP_SHIFT;
  assign idx    = (scaled > 32'(EXP_DEPTH - 1)) ? EXP_IDX_W'(EXP_DEPTH - 1)
                                                : scaled[EXP_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      v1      <= issue;
      v2      <= v1;
      w_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    gap1 <= diff[SCORE_W] ? '0 : diff[SCORE_W-1:0];
    id1  <= id;
    mag2 <= 32'(gap1) * 32'(inv_temp);
    id2  <= id1;
    w    <= (mag2 > EXP_ARG_LIMIT) ? '0 : EXP_TABLE[idx];
    w_id <= id2;
  end

endmodule
`default_nettype wire

// ----- design/top_k_temperature_sampler.sv -----
// Top level of the top-k sampler with temperature: configuration registers,
// run sequencer, ranking chain and weight pipeline. Depends on tks_pkg,
// tks_stream_if, tks_cell and tks_weight.
//
//   Channel    Kind            Moves
//   logit_in   stream sink     one logit (logit_score, run_last, random_word)
//   token_out  stream source   one chosen token_id at the end of each run
//   apb        register port   kept_limit, greedy_mode, temp_scale
//
// While a run streams in, one logit is taken every cycle: the ranking chain
// places each score as it is taken, every cell comparing against the new
// score and looking only at its upper neighbor. After the item that ends a
// run, greedy mode or a limit of one gives the top id from cell 0. While
// sampling, the chain is rotated once through the weight pipeline to sum the
// weights, the S_TARGET state forms the target, and a second rotation finds
// the pick. Input is held off while sampling; the result waits in an output
// register, so a stalled token_out only holds the block at the point where a
// new result must be written. rst is synchronous and empties the chain and
// the registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none
module top_k_temperature_sampler #(
  parameter int MAX_KEPT    = 64,
  parameter int VOCAB_LIMIT = 8192
) (
  input  wire               clk,
  input  wire               rst,
  tks_logit_if.sink         logit_in,
  tks_token_if.source       token_out,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [3:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready
);
  import tks_pkg::*;

  localparam int ID_W   = $clog2(VOCAB_LIMIT);
  localparam int CNT_W  = $clog2(VOCAB_LIMIT + 1);
  localparam int K_W    = $clog2(MAX_KEPT + 1);
  localparam int STEP_W = $clog2(MAX_KEPT + WEIGHT_LAT);
  localparam int SUM_W  = WEIGHT_W + $clog2(MAX_KEPT + 1);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(MAX_KEPT + WEIGHT_LAT - 1);

  // Sequencer states.
  localparam logic [2:0] S_COLLECT = 3'd0;
  localparam logic [2:0] S_TOP     = 3'd1;
  localparam logic [2:0] S_PREP    = 3'd2;
  localparam logic [2:0] S_SUM     = 3'd3;
  localparam logic [2:0] S_TARGET  = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  // Configuration registers.
  logic [KLIM_W-1:0] kept_limit;
  logic              greedy_mode;
  logic [INVT_W-1:0] temp_scale;

  logic [2:0]               state;
  logic [CNT_W-1:0]         item_index;
  logic [STEP_W-1:0]        step;
  logic signed [SCORE_W-1:0] top_score;
  logic [RAND_W-1:0]        random_q;
  logic [SUM_W-1:0]         weight_sum;
  logic [SUM_W-1:0]         target;
  logic [SUM_W-1:0]         running;
  logic [SUM_W-1:0]         running_next;
  logic [RAND_W+SUM_W-1:0]  product;
  logic                     found;
  logic [ID_W-1:0]          result_id;

  logic                     in_fire;
  logic                     ranked;
  logic                     out_free;
  logic                     issue;
  logic                     hit;
  logic [K_W-1:0]           limit_k;
  tks_cell_ctrl_t           cell_ctrl;

  // Chain signals, one per cell.
  logic                      c_ins   [MAX_KEPT];
  logic signed [SCORE_W-1:0] c_score [MAX_KEPT];
  logic        [ID_W-1:0]    c_id    [MAX_KEPT];
  logic                      c_valid [MAX_KEPT];
  logic                      c_range [MAX_KEPT];

  logic                w_valid;
  logic [WEIGHT_W-1:0] w;
  logic [ID_W-1:0]     w_id;

  // ---------------------------------------------------------------------
  // Configuration port. Register i sits at byte address 4*i; the low two
  // address bits are not decoded.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_limit  <= KEPT_LIMIT_RST;
      greedy_mode <= 1'b0;
      temp_scale  <= INV_TEMP_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_KEPT_LIMIT: kept_limit  <= pwdata[KLIM_W-1:0];
        REG_GREEDY:     greedy_mode <= pwdata[0];
        REG_INV_TEMP:   temp_scale  <= pwdata[INVT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KEPT_LIMIT: prdata = 32'(kept_limit);
      REG_GREEDY:     prdata = 32'(greedy_mode);
      REG_INV_TEMP:   prdata = 32'(temp_scale);
      default:        prdata = '0;
    endcase
  end

  // The effective limit: zero acts as one, and anything above the chain
  // length acts as the chain length.
  always_comb begin
    if (kept_limit == '0) begin
      limit_k = K_W'(1);
    end else if (32'(kept_limit) > 32'(MAX_KEPT)) begin
      limit_k = K_W'(MAX_KEPT);
    end else begin
      limit_k = K_W'(kept_limit);
    end
  end

  // ---------------------------------------------------------------------
  // Handshakes and chain commands.
  // ---------------------------------------------------------------------
  assign logit_in.ready = (state == S_COLLECT);
  assign in_fire        = logit_in.valid && logit_in.ready;
  assign ranked         = item_index < CNT_W'(VOCAB_LIMIT);
  assign out_free       = !token_out.valid || token_out.ready;
  assign issue          = ((state == S_SUM) || (state == S_SCAN)) &&
                          (32'(step) < 32'(MAX_KEPT));

  // Past the vocabulary an item is not ranked, but the item that ends the
  // run still cuts the list to the limit so that the rotation sees only
  // entries that take part in the pick.
  assign cell_ctrl.insert = in_fire && ranked;
  assign cell_ctrl.trim   = in_fire && (ranked || logit_in.run_last);
  assign cell_ctrl.rotate = issue;
  assign cell_ctrl.clear  = (state == S_EMIT) && out_free;

  // ---------------------------------------------------------------------
  // Ranking chain, best score at cell 0. While sampling, the chain rotates
  // toward cell 0 and the head wraps around to the tail, so a full pass of
  // MAX_KEPT steps leaves the list as it was.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    logic                      p_ins;
    logic signed [SCORE_W-1:0] p_score;
    logic        [ID_W-1:0]    p_id;
    logic                      p_valid;
    localparam int NX = (i == MAX_KEPT - 1) ? 0 : i + 1;

    assign c_range[i] = 32'(i) < 32'(limit_k);

    if (i == 0) begin : g_head
      assign p_ins   = 1'b0;
      assign p_score = '0;
      assign p_id    = '0;
      assign p_valid = 1'b0;
    end else begin : g_body
      assign p_ins   = c_ins[i-1];
      assign p_score = c_score[i-1];
      assign p_id    = c_id[i-1];
      assign p_valid = c_valid[i-1];
    end

    tks_cell #(
      .ID_W (ID_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .in_range   (c_range[i]),
      .new_score  (logit_in.logit_score),
      .new_id     (item_index[ID_W-1:0]),
      .prev_ins   (p_ins),
      .prev_score (p_score),
      .prev_id    (p_id),
      .prev_valid (p_valid),
      .next_score (c_score[NX]),
      .next_id    (c_id[NX]),
      .next_valid (c_valid[NX]),
      .ins        (c_ins[i]),
      .score      (c_score[i]),
      .id         (c_id[i]),
      .valid      (c_valid[i])
    );
  end

  // Weight of the entry now at the head of the chain. Empty cells are not
  // issued, so they add nothing to the sum and are never picked.
  tks_weight #(
    .ID_W (ID_W)
  ) u_weight (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue && c_valid[0]),
    .top_score (top_score),
    .score     (c_score[0]),
    .id        (c_id[0]),
    .inv_temp  (temp_scale),
    .w_valid   (w_valid),
    .w         (w),
    .w_id      (w_id)
  );

  assign product      = random_q * weight_sum;
  assign running_next = running + SUM_W'(w);
  assign hit          = target <= running_next;

  // ---------------------------------------------------------------------
  // Run sequencer.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      item_index <= '0;
      step       <= '0;
      found      <= 1'b0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (in_fire) begin
            if (logit_in.run_last) begin
              item_index <= '0;
              if (greedy_mode || (limit_k == K_W'(1))) begin
                state <= S_TOP;
              end else begin
                state <= S_PREP;
              end
            end else if (ranked) begin
              item_index <= item_index + CNT_W'(1);
            end
          end
        end
        S_TOP: begin
          state <= S_EMIT;
        end
        S_PREP: begin
          step  <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (step == STEP_END) begin
            step  <= '0;
            state <= S_TARGET;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_TARGET: begin
          found <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (w_valid && !found && hit) begin
            found <= 1'b1;
          end
          if (step == STEP_END) begin
            step  <= '0;
            state <= S_EMIT;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_COLLECT;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  // Sampling datapath. Until the pick is found each weighted entry becomes
  // the candidate, so when no running sum reaches the target the last kept
  // entry stands.
  always_ff @(posedge clk) begin
    if (in_fire && logit_in.run_last) begin
      random_q <= logit_in.random_word;
    end
    if (state == S_PREP) begin
      top_score  <= c_score[0];
      weight_sum <= '0;
    end
    if ((state == S_SUM) && w_valid) begin
      weight_sum <= weight_sum + SUM_W'(w);
    end
    if (state == S_TARGET) begin
      target  <= product[RAND_W+SUM_W-1:RAND_W];
      running <= '0;
    end
    if ((state == S_SCAN) && w_valid) begin
      running <= running_next;
      if (!found) begin
        result_id <= w_id;
      end
    end
    if (state == S_TOP) begin
      result_id <= c_id[0];
    end
  end

  // Output register: the token waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      token_out.valid <= 1'b1;
    end else if (token_out.ready) begin
      token_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      token_out.token_id <= TOKEN_W'(result_id);
    end
  end

endmodule
`default_nettype wire
